// ===== design/sorted_two_level_timer_queue_core_assert.svh =====
// Assertion macros for the sorted two-level timer queue.
`ifndef SORTED_TWO_LEVEL_TIMER_QUEUE_CORE_ASSERT_SVH
`define SORTED_TWO_LEVEL_TIMER_QUEUE_CORE_ASSERT_SVH
// Same-cycle implication, sampled on the rising edge outside reset.
`define STQT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on the rising edge outside reset.
`define STQT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/stqt_pkg.sv =====
// Types, constants and codes shared by the timer queue modules.
`default_nettype none
package stqt_pkg;
  localparam int SHORT_DEPTH = 32;
  localparam int LONG_DEPTH  = 32;
  localparam int JOB_SLOTS   = 64;
  localparam int SLOT_W      = $clog2(JOB_SLOTS);
  localparam int HEAD_W      = SLOT_W + 1;
  localparam int SCNT_W      = $clog2(SHORT_DEPTH);
  localparam int LCNT_W      = $clog2(LONG_DEPTH);
  localparam int FIFO_DEPTH  = 2;

  localparam logic [15:0] REBASE_AT   = 16'd32000;
  localparam logic [15:0] MAX_DELAY   = 16'd32000;
  localparam logic [15:0] NO_EXPIRY   = 16'hFFFF;
  localparam logic [14:0] LIMIT_RESET = 15'd100;

  localparam logic [2:0] ERR_OK         = 3'd0;
  localparam logic [2:0] ERR_SHORT_FULL = 3'd1;
  localparam logic [2:0] ERR_LONG_FULL  = 3'd2;
  localparam logic [2:0] ERR_TOO_LONG   = 3'd3;
  localparam logic [2:0] ERR_NO_SLOT    = 3'd4;

  typedef struct packed {
    logic        action;
    logic [15:0] delay;
  } item_t;

  typedef struct packed {
    logic [5:0] job_slot;
    logic       slot_valid;
    logic [2:0] error;
    logic       last;
  } result_t;

  typedef enum logic [1:0] {CMD_TICK, CMD_SHORT, CMD_LONG, CMD_TOO_LONG} cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] delay;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic [15:0]       tm;
    logic [SLOT_W-1:0] slot;
  } qent_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_INSERT, BK_LINK, BK_TICK, BK_CHECK, BK_DRAIN_S, BK_DRAIN_L
  } bk_state_t;
endpackage
`default_nettype wire

// ===== design/stqt_cmd_fifo.sv =====
// Short command queue between the front and the back.
`default_nettype none
module stqt_cmd_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire stqt_pkg::cmd_t      push_data,
  input  wire logic                pop,
  output stqt_pkg::cmd_t           pop_data,
  output stqt_pkg::fifo_stat_t     stat
);
  import stqt_pkg::*;
  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign pop_data   = mem[rd_ptr];
  assign stat.full  = (count == CNT_W'(FIFO_DEPTH));
  assign stat.empty = (count == '0);

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end
endmodule
`default_nettype wire

// ===== design/stqt_front.sv =====
// Front end: takes input beats and classifies them into queue commands.
`default_nettype none
module stqt_front (
  input  wire logic                 start,
  input  wire stqt_pkg::item_t      item,
  input  wire logic [14:0]          short_limit,
  input  wire stqt_pkg::fifo_stat_t stat,
  output logic                      busy,
  output logic                      push,
  output stqt_pkg::cmd_t            push_data
);
  import stqt_pkg::*;

  logic [15:0] delay_eff;

  assign busy      = stat.full;
  assign push      = start && !stat.full;
  assign delay_eff = (item.delay == '0) ? 16'd1 : item.delay;

  // Queue choice is made here so that the back end only checks capacity.
  always_comb begin
    push_data.delay = delay_eff;
    if (item.action) begin
      push_data.kind = CMD_TICK;
    end else if (delay_eff < {1'b0, short_limit}) begin
      push_data.kind = CMD_SHORT;
    end else if (delay_eff <= MAX_DELAY) begin
      push_data.kind = CMD_LONG;
    end else begin
      push_data.kind = CMD_TOO_LONG;
    end
  end
endmodule
`default_nettype wire

// ===== design/stqt_back.sv =====
// Back end: sorted queues, free slot list, tick counter and result beats.
`default_nettype none
module stqt_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire stqt_pkg::fifo_stat_t stat,
  input  wire stqt_pkg::cmd_t       cmd_in,
  output logic                      pop_cmd,
  output logic                      result_valid,
  output stqt_pkg::result_t         result
);
  import stqt_pkg::*;

  bk_state_t state, state_next;
  cmd_t      cmd;

  qent_t             sq [SHORT_DEPTH];
  qent_t             lq [LONG_DEPTH];
  qent_t             s_ins_d [SHORT_DEPTH];
  qent_t             s_pop_d [SHORT_DEPTH];
  qent_t             l_ins_d [LONG_DEPTH];
  qent_t             l_pop_d [LONG_DEPTH];
  logic [SHORT_DEPTH-1:0] s_le;
  logic [LONG_DEPTH-1:0]  l_le;
  logic [SCNT_W-1:0] scnt;
  logic [LCNT_W-1:0] lcnt;

  logic [HEAD_W-1:0] links [JOB_SLOTS];
  logic [JOB_SLOTS-1:0] link_vld;
  logic [HEAD_W-1:0] free_head, head_link, lk_rd, lk_val;
  logic              lk_rd_vld;
  logic [SLOT_W-1:0] lk_rd_addr;

  logic [14:0] now, now_p1;
  logic [15:0] now16, next_exp, exp_t;
  logic        emitted;
  qent_t       new_ent;
  logic [2:0]  ins_err;
  logic        s_exp, s_more, l_exp, l_more, rebase;

  logic              take, give, ins_s, ins_l, pop_s, pop_l, res_valid_next;
  logic [SLOT_W-1:0] give_slot;
  result_t           res_next;

  assign now16   = {1'b0, now};
  assign now_p1  = now + 1'b1;
  assign exp_t   = now16 + cmd.delay;
  assign new_ent = '{tm: exp_t, slot: free_head[SLOT_W-1:0]};
  assign rebase  = (state == BK_TICK) && (now_p1 == REBASE_AT[14:0]);
  assign lk_val  = lk_rd_vld ? lk_rd : HEAD_W'({1'b0, lk_rd_addr} + HEAD_W'(1));

  assign s_exp  = (scnt != '0) && (sq[0].tm <= now16);
  assign s_more = (scnt > SCNT_W'(1)) && (sq[1].tm <= now16);
  assign l_exp  = (lcnt != '0) && (lq[0].tm <= now16);
  assign l_more = (lcnt > LCNT_W'(1)) && (lq[1].tm <= now16);

  // Per-cell insert and shift sources; the entries at or below the new
  // expiry form a prefix, so each cell only looks at its neighbour.
  for (genvar i = 0; i < SHORT_DEPTH; i++) begin : g_sq
    assign s_le[i] = (i < scnt) && (sq[i].tm <= exp_t);
    if (i == 0) begin : g_first
      assign s_ins_d[i] = new_ent;
    end else begin : g_rest
      assign s_ins_d[i] = s_le[i-1] ? new_ent : sq[i-1];
    end
    if (i == SHORT_DEPTH - 1) begin : g_top
      assign s_pop_d[i] = sq[i];
    end else begin : g_mid
      assign s_pop_d[i] = sq[i+1];
    end
  end

  for (genvar i = 0; i < LONG_DEPTH; i++) begin : g_lq
    assign l_le[i] = (i < lcnt) && (lq[i].tm <= exp_t);
    if (i == 0) begin : g_first
      assign l_ins_d[i] = new_ent;
    end else begin : g_rest
      assign l_ins_d[i] = l_le[i-1] ? new_ent : lq[i-1];
    end
    if (i == LONG_DEPTH - 1) begin : g_top
      assign l_pop_d[i] = lq[i];
    end else begin : g_mid
      assign l_pop_d[i] = lq[i+1];
    end
  end

  // Insert checks in priority order: free list first, then the delay range and the queues.
  always_comb begin
    if (free_head[SLOT_W]) begin
      ins_err = ERR_NO_SLOT;
    end else begin
      unique case (cmd.kind)
        CMD_TOO_LONG: ins_err = ERR_TOO_LONG;
        CMD_SHORT: ins_err = (scnt >= SCNT_W'(SHORT_DEPTH - 1)) ? ERR_SHORT_FULL : ERR_OK;
        CMD_LONG: ins_err = (lcnt >= LCNT_W'(LONG_DEPTH - 1)) ? ERR_LONG_FULL : ERR_OK;
        default: ins_err = ERR_OK;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!stat.empty) begin
          state_next = (cmd_in.kind == CMD_TICK) ? BK_TICK : BK_INSERT;
        end
      end
      BK_INSERT: state_next = (ins_err == ERR_OK) ? BK_LINK : BK_IDLE;
      BK_LINK: state_next = BK_IDLE;
      BK_TICK: state_next = BK_CHECK;
      BK_CHECK: state_next = (next_exp <= now16) ? BK_DRAIN_S : BK_IDLE;
      BK_DRAIN_S: state_next = s_exp ? BK_DRAIN_S : BK_DRAIN_L;
      BK_DRAIN_L: state_next = l_exp ? BK_DRAIN_L : BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // Outputs and datapath controls.
  always_comb begin
    pop_cmd        = 1'b0;
    take           = 1'b0;
    give           = 1'b0;
    give_slot      = '0;
    ins_s          = 1'b0;
    ins_l          = 1'b0;
    pop_s          = 1'b0;
    pop_l          = 1'b0;
    res_valid_next = 1'b0;
    res_next       = '0;
    unique case (state)
      BK_IDLE: pop_cmd = !stat.empty;
      BK_INSERT: begin
        res_valid_next = 1'b1;
        res_next.last  = 1'b1;
        res_next.error = ins_err;
        if (ins_err == ERR_OK) begin
          res_next.slot_valid = 1'b1;
          res_next.job_slot   = 6'(free_head[SLOT_W-1:0]);
          take  = 1'b1;
          ins_s = (cmd.kind == CMD_SHORT);
          ins_l = (cmd.kind == CMD_LONG);
        end
      end
      BK_CHECK: begin
        if (!(next_exp <= now16)) begin
          res_valid_next = 1'b1;
          res_next.last  = 1'b1;
        end
      end
      BK_DRAIN_S: begin
        if (s_exp) begin
          pop_s               = 1'b1;
          give                = 1'b1;
          give_slot           = sq[0].slot;
          res_valid_next      = 1'b1;
          res_next.slot_valid = 1'b1;
          res_next.job_slot   = 6'(sq[0].slot);
          res_next.last       = !s_more && !l_exp;
        end
      end
      BK_DRAIN_L: begin
        if (l_exp) begin
          pop_l               = 1'b1;
          give                = 1'b1;
          give_slot           = lq[0].slot;
          res_valid_next      = 1'b1;
          res_next.slot_valid = 1'b1;
          res_next.job_slot   = 6'(lq[0].slot);
          res_next.last       = !l_more;
        end else if (!emitted) begin
          res_valid_next = 1'b1;
          res_next.last  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      scnt         <= '0;
      lcnt         <= '0;
      free_head    <= '0;
      head_link    <= HEAD_W'(1);
      link_vld     <= '0;
      now          <= '0;
      next_exp     <= NO_EXPIRY;
      emitted      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= res_valid_next;
      if (ins_s) begin
        scnt <= scnt + 1'b1;
      end else if (pop_s) begin
        scnt <= scnt - 1'b1;
      end
      if (ins_l) begin
        lcnt <= lcnt + 1'b1;
      end else if (pop_l) begin
        lcnt <= lcnt - 1'b1;
      end
      // Free list: pop on insert, refill the head link from memory, push on expiry.
      if (take) begin
        free_head <= head_link;
      end
      if (state == BK_LINK) begin
        head_link <= lk_val;
      end
      if (give) begin
        link_vld[give_slot] <= 1'b1;
        free_head           <= {1'b0, give_slot};
        head_link           <= free_head;
      end
      // Time keeping and earliest expiry.
      if (take && (exp_t < next_exp)) begin
        next_exp <= exp_t;
      end
      if (state == BK_TICK) begin
        if (rebase) begin
          now      <= '0;
          next_exp <= next_exp - REBASE_AT;
        end else begin
          now <= now_p1;
        end
      end
      if ((state == BK_CHECK) && (next_exp <= now16)) begin
        next_exp <= NO_EXPIRY;
        emitted  <= 1'b0;
      end
      if (state == BK_DRAIN_S) begin
        if (s_exp) begin
          emitted <= 1'b1;
        end else if (scnt != '0) begin
          next_exp <= sq[0].tm;
        end
      end
      if (state == BK_DRAIN_L) begin
        if (l_exp) begin
          emitted <= 1'b1;
        end else if ((lcnt != '0) && (next_exp > lq[0].tm)) begin
          next_exp <= lq[0].tm;
        end
      end
    end
  end

  // Payload registers, link memory and the queue cells.
  always_ff @(posedge clk) begin
    result <= res_next;
    if (pop_cmd) begin
      cmd <= cmd_in;
    end
    if (give) begin
      links[give_slot] <= free_head;
    end
    lk_rd      <= links[head_link[SLOT_W-1:0]];
    lk_rd_vld  <= link_vld[head_link[SLOT_W-1:0]];
    lk_rd_addr <= head_link[SLOT_W-1:0];
    for (int i = 0; i < SHORT_DEPTH; i++) begin
      if (ins_s && !s_le[i]) begin
        sq[i] <= s_ins_d[i];
      end else if (pop_s) begin
        sq[i] <= s_pop_d[i];
      end else if (rebase) begin
        sq[i].tm <= sq[i].tm - REBASE_AT;
      end
    end
    for (int i = 0; i < LONG_DEPTH; i++) begin
      if (ins_l && !l_le[i]) begin
        lq[i] <= l_ins_d[i];
      end else if (pop_l) begin
        lq[i] <= l_pop_d[i];
      end else if (rebase) begin
        lq[i].tm <= lq[i].tm - REBASE_AT;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/sorted_two_level_timer_queue_core.sv =====
// Insert: the back end takes the command through dispatch, sorted insert (which
// registers the result beat) and a free-list link read from memory.
// Tick: one result beat when nothing expires, else the expired slots one per
// cycle, short queue first, with a gap at the queue hand-over; a two-entry
// command queue takes start meanwhile.
// Synchronous active-high reset empties both queues, refills the free list
// via per-slot valid bits and sets short_limit to 100; results cannot be stalled.
`default_nettype none
`include "sorted_two_level_timer_queue_core_assert.svh"
module sorted_two_level_timer_queue_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire stqt_pkg::item_t   item,
  input  wire logic              cfg_we,
  input  wire logic [14:0]       cfg_data,
  output logic                   result_valid,
  output stqt_pkg::result_t      result
);
  import stqt_pkg::*;

  logic       [14:0] short_limit;
  fifo_stat_t stat;
  cmd_t       push_data, pop_data;
  logic       push, pop;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      short_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      short_limit <= cfg_data;
    end
  end

  stqt_front u_front (
    .start(start), .item(item), .short_limit(short_limit), .stat(stat),
    .busy(busy), .push(push), .push_data(push_data)
  );

  stqt_cmd_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .pop(pop), .pop_data(pop_data), .stat(stat)
  );

  stqt_back u_back (
    .clk(clk), .rst(rst), .stat(stat), .cmd_in(pop_data), .pop_cmd(pop),
    .result_valid(result_valid), .result(result)
  );

  // A rejected insert never hands out a slot.
  `STQT_ASSERT_IMP(a_err_no_slot, result_valid && (result.error != ERR_OK), !result.slot_valid, "error beat carries a slot")
  // Error codes stay within the defined set.
  `STQT_ASSERT_IMP(a_err_range, result_valid, result.error <= ERR_NO_SLOT, "undefined error code")
  // An accepted beat always lands in the command queue.
  `STQT_ASSERT_NEXT(a_push_lands, start && !busy, !stat.empty, "accepted beat lost")
endmodule
`default_nettype wire

// ===== tb/stqt_checker.sv =====
// Predicts the timer queue's results and checks every result beat against them.
module stqt_checker
  import stqt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire logic    busy,
  input  wire item_t   item,
  input  wire logic    cfg_we,
  input  wire logic [14:0] cfg_data,
  input  wire logic    result_valid,
  input  wire result_t result,
  output int           fail_count,
  output int           due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_TICK   = 1'b1;
  localparam int   Q_SHORT    = 0;
  localparam int   Q_LONG     = 1;

  // Model of the queues, the free list and the time base.
  logic [15:0] q_tm [2][64];
  logic [5:0]  q_sl [2][64];
  int          q_cnt [2];
  logic [6:0]  free_link [JOB_SLOTS];
  logic [6:0]  free_head;
  logic [15:0] now_t;
  logic [15:0] next_exp;
  logic [14:0] short_limit;
  result_t     due_results [$];

  initial begin
    fail_count = 0;
    due_count  = 0;
  end

  function automatic void push_result(input logic [5:0] slot, input logic valid,
                                      input logic [2:0] err);
    result_t r;
    r.job_slot   = slot;
    r.slot_valid = valid;
    r.error      = err;
    r.last       = 1'b0;
    due_results.push_back(r);
  endfunction

  function automatic void place_entry(input int w, input logic [15:0] expiry,
                                      input logic [5:0] slot);
    int pos;
    pos = 0;
    while (pos < q_cnt[w] && q_tm[w][pos] <= expiry) pos++;
    for (int j = q_cnt[w]; j > pos; j--) begin
      q_tm[w][j] = q_tm[w][j-1];
      q_sl[w][j] = q_sl[w][j-1];
    end
    q_tm[w][pos] = expiry;
    q_sl[w][pos] = slot;
    q_cnt[w]++;
  endfunction

  // Emit and free every expired entry at the head of one queue.
  function automatic void expire_queue(input int w);
    int n;
    n = 0;
    while (n < q_cnt[w] && q_tm[w][n] <= now_t) begin
      free_link[q_sl[w][n]] = free_head;
      free_head = {1'b0, q_sl[w][n]};
      push_result(q_sl[w][n], 1'b1, ERR_OK);
      n++;
    end
    for (int j = n; j < q_cnt[w]; j++) begin
      q_tm[w][j-n] = q_tm[w][j];
      q_sl[w][j-n] = q_sl[w][j];
    end
    q_cnt[w] -= n;
  endfunction

  function automatic void predict_insert(input logic [15:0] delay);
    logic [16:0] d;
    logic [15:0] expiry;
    logic [5:0]  slot;
    int          w;
    d = {1'b0, delay};
    if (d == 0) d = 1;
    w = -1;
    if (free_head >= JOB_SLOTS) push_result('0, 1'b0, ERR_NO_SLOT);
    else if (d < {2'b00, short_limit}) w = Q_SHORT;
    else if (d <= {1'b0, MAX_DELAY}) w = Q_LONG;
    else push_result('0, 1'b0, ERR_TOO_LONG);
    if (w == Q_SHORT && q_cnt[w] >= SHORT_DEPTH - 1) begin
      push_result('0, 1'b0, ERR_SHORT_FULL);
    end else if (w == Q_LONG && q_cnt[w] >= LONG_DEPTH - 1) begin
      push_result('0, 1'b0, ERR_LONG_FULL);
    end else if (w >= 0) begin
      slot = free_head[5:0];
      free_head = free_link[slot];
      expiry = now_t + d[15:0];
      if (expiry < next_exp) next_exp = expiry;
      place_entry(w, expiry, slot);
      push_result(slot, 1'b1, ERR_OK);
    end
  endfunction

  function automatic void predict_tick();
    int n_prior;
    n_prior = due_results.size();
    now_t = now_t + 16'd1;
    // Rebase all times once the tick counter reaches the wrap point.
    if (now_t == REBASE_AT) begin
      now_t = '0;
      next_exp = next_exp - REBASE_AT;
      for (int w = 0; w < 2; w++)
        for (int i = 0; i < q_cnt[w]; i++) q_tm[w][i] = q_tm[w][i] - REBASE_AT;
    end
    if (next_exp <= now_t) begin
      next_exp = NO_EXPIRY;
      expire_queue(Q_SHORT);
      if (q_cnt[Q_SHORT] != 0) next_exp = q_tm[Q_SHORT][0];
      expire_queue(Q_LONG);
      if (q_cnt[Q_LONG] != 0 && next_exp > q_tm[Q_LONG][0]) next_exp = q_tm[Q_LONG][0];
    end
    if (due_results.size() == n_prior) push_result('0, 1'b0, ERR_OK);
  endfunction

  // Compare, then update the configuration, then predict any accepted beat.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      q_cnt[Q_SHORT] = 0;
      q_cnt[Q_LONG]  = 0;
      for (int i = 0; i < JOB_SLOTS; i++) free_link[i] = 7'(i + 1);
      free_head   = '0;
      now_t       = '0;
      next_exp    = NO_EXPIRY;
      short_limit = LIMIT_RESET;
      due_results.delete();
    end else begin
      if (result_valid) begin
        if (due_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("checker: result beat with none expected: slot %0d valid %0b err %0d last %0b",
                     result.job_slot, result.slot_valid, result.error, result.last);
        end else begin
          want = due_results.pop_front();
          if (result.job_slot !== want.job_slot || result.slot_valid !== want.slot_valid ||
              result.error !== want.error || result.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("checker: mismatch: expected slot %0d valid %0b err %0d last %0b, got slot %0d valid %0b err %0d last %0b",
                       want.job_slot, want.slot_valid, want.error, want.last,
                       result.job_slot, result.slot_valid, result.error, result.last);
          end
        end
      end
      if (cfg_we) short_limit = cfg_data;
      if (start && !busy) begin
        if (item.action == ACT_INSERT) predict_insert(item.delay);
        else predict_tick();
        due_results[due_results.size()-1].last = 1'b1;
      end
    end
    due_count = due_results.size();
  end
endmodule

// ===== tb/tb.sv =====
// Stimulus and verdict for the sorted two-level timer queue.
module tb;
  import stqt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_TICK    = 1'b1;
  localparam int   CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  item_t       item = '0;
  logic        cfg_we = 1'b0;
  logic [14:0] cfg_data = '0;
  logic        busy;
  logic        result_valid;
  result_t     result;
  int          fail_count;
  int          due_count;
  int          cycle_count = 0;
  int          burst_left = 0;

  always #6 clk = ~clk;

  sorted_two_level_timer_queue_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .result_valid(result_valid), .result(result)
  );

  stqt_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .result_valid(result_valid), .result(result),
    .fail_count(fail_count), .due_count(due_count)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one beat and hold it until accepted; bursts may end in a random gap.
  task automatic send(input logic action, input logic [15:0] delay);
    @(negedge clk);
    start <= 1'b1;
    item.action <= action;
    item.delay  <= delay;
    do @(posedge clk); while (busy);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 11);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
  endtask

  task automatic insert(input logic [15:0] delay);
    send(ACT_INSERT, delay);
  endtask

  task automatic tick(input int n);
    repeat (n) send(ACT_TICK, 16'($urandom));
  endtask

  // Wait until every expected result is in, plus the queue hand-over.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic set_limit(input logic [14:0] value);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random inserts and ticks, delays spread around the given limit.
  task automatic random_phase(input int n, input logic [14:0] limit);
    logic [15:0] d;
    repeat (n) begin
      if ($urandom_range(0, 9) < 4) begin
        tick(1);
      end else begin
        case ($urandom_range(0, 4))
          0: d = 16'($urandom_range(0, 40));
          1: d = 16'({1'b0, limit}) + 16'($urandom_range(0, 3)) - 16'd2;
          2: d = 16'($urandom_range(0, 200));
          3: d = 16'($urandom);
          default: d = 16'($urandom_range(31990, 32010));
        endcase
        insert(d);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: delay extremes, queue choice, errors and ticks.
    insert(16'd0);
    insert(16'd1);
    insert(16'd99);
    insert(16'd100);
    insert(16'd32000);
    insert(16'd32001);
    insert(16'hFFFF);
    send(ACT_TICK, 16'hFFFF);
    tick(3);

    // Limit at all ones: a delay above the long maximum is still rejected as too long.
    set_limit(15'h7FFF);
    insert(16'hFFFF);
    repeat (31) insert(16'($urandom_range(2, 30)));
    tick(4);

    // Limit of zero: everything goes long, until the long queue is full.
    set_limit(15'd0);
    repeat (32) insert(16'($urandom_range(0, 20)));
    tick(40);

    // Limit at the long maximum: both sides of it.
    set_limit(15'd32000);
    insert(16'd31999);
    insert(16'd32000);

    // Random phases under several limits.
    set_limit(15'd1);
    random_phase(50, 15'd1);
    set_limit(15'd100);
    random_phase(50, 15'd100);
    set_limit(15'($urandom_range(2, 32000)));
    random_phase(50, 15'd20);
    set_limit(15'h7FFF);
    random_phase(50, 15'h7FFF);
    set_limit(15'd40);
    random_phase(50, 15'd40);
    tick(10);

    settle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
